>>> rtl/pfde_pkg.sv
// Shared constants and command codes of the page framebuffer draw engine.
package pfde_pkg;

    // Rows covered by one page; one store byte is one column of one page.
    localparam int PAGE_ROWS = 8;

    // Command codes carried in the slave-side tuser.
    localparam logic [2:0] OP_PIXEL = 3'd0;
    localparam logic [2:0] OP_HLINE = 3'd1;
    localparam logic [2:0] OP_VLINE = 3'd2;
    localparam logic [2:0] OP_RECT  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;
    localparam logic [2:0] OP_READ  = 3'd5;

    // Port widths.
    localparam int OP_W      = 3;
    localparam int IN_DATA_W = 48;
    localparam int OUT_W     = 8;

endpackage

>>> rtl/pfde_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module pfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/page_framebuffer_draw_engine.sv
// Page framebuffer draw engine: one drawing command per word into a 1-bpp page store.
// Each word is drawn, cleared or read before its result is posted; a line or rectangle of zero size
// and an unknown command go straight to posting. m_tvalid rises in the cycle after the posting cycle,
// and a stalled m_tready stretches the posting cycle.
// Throughput: one pixel read-modify-write per cycle, set by the store's single write port.
// Reset: a clearing pass over all COLUMNS*PAGES bytes zeroes the store; s_tready stays low until it ends.
module page_framebuffer_draw_engine #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [7:0] pos_x, [15:8] pos_y, [23:16] span, [31:24] tall, [32] ink,
    // [42:33] byte_index, [47:43] zero
    input  logic [pfde_pkg::IN_DATA_W-1:0]  s_tdata,
    // [2:0] op
    input  logic [pfde_pkg::OP_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] read_byte
    output logic [pfde_pkg::OUT_W-1:0]      m_tdata
);

    import pfde_pkg::*;

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int ROWS  = PAGE_ROWS * PAGES;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW,
        ST_DRAIN,
        ST_CLEAR,
        ST_READ,
        ST_RDWAIT,
        ST_DONE
    } state_t;

    // Control registers.
    state_t          state_reg, state_next;
    logic            drain_reg, drain_next;
    logic            clr_cmd_reg, clr_cmd_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic            p1_valid_reg, p1_valid_next;
    logic            p2_valid_reg, p2_valid_next;
    logic            wl_valid_reg, wl_valid_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_data_reg, out_data_next;

    // Command and datapath registers.
    logic [2:0]      op_reg, op_next;
    logic [7:0]      x0_reg, x0_next;
    logic [7:0]      y0_reg, y0_next;
    logic [7:0]      span_reg, span_next;
    logic [7:0]      tall_reg, tall_next;
    logic            ink_reg, ink_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [7:0]      cnt_reg, cnt_next;
    logic            side_reg, side_next;
    logic            phase_reg, phase_next;
    logic [7:0]      res_reg, res_next;
    logic [7:0]      p1_x_reg, p1_x_next;
    logic [7:0]      p1_y_reg, p1_y_next;
    logic            p1_on_reg, p1_on_next;
    logic [AW-1:0]   p2_addr_reg, p2_addr_next;
    logic [2:0]      p2_bit_reg, p2_bit_next;
    logic            p2_on_reg, p2_on_next;
    logic [AW-1:0]   wl_addr_reg, wl_addr_next;
    logic [7:0]      wl_data_reg, wl_data_next;

    // Store ports.
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;

    // Pixel generator outputs.
    logic [7:0]      gx, gy;
    logic            gon;
    logic            line_end, top_end, side_end;

    // Stage signals.
    logic            on_screen;
    logic [31:0]     addr_w;
    logic [AW-1:0]   addr1;
    logic [7:0]      base_byte, bit_mask, new_byte;

    // Input unpacking.
    logic            s_accept;
    logic [31:0]     in_idx_w;

    assign s_accept = s_tvalid && s_tready;
    assign in_idx_w = 32'(s_tdata[42:33]);

    pfde_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Pixel generator: the current pixel of the walking line or outline.
    always_comb
    begin
        line_end = (cnt_reg == 8'(span_reg - 8'd1));
        top_end  = side_reg && line_end;
        side_end = side_reg && (cnt_reg == 8'(tall_reg - 8'd3));
        gon      = (op_reg == OP_PIXEL) ? ink_reg : 1'b1;
        gx       = x0_reg;
        gy       = y0_reg;
        case (op_reg)
            OP_HLINE:
            begin
                gx = 8'(x0_reg + cnt_reg);
            end
            OP_VLINE:
            begin
                gy = 8'(y0_reg + cnt_reg);
            end
            OP_RECT:
            begin
                if (!phase_reg)
                begin
                    gx = 8'(x0_reg + cnt_reg);
                    gy = side_reg ? 8'(y0_reg + tall_reg - 8'd1) : y0_reg;
                end
                else
                begin
                    gx = side_reg ? 8'(x0_reg + span_reg - 8'd1) : x0_reg;
                    gy = 8'(y0_reg + 8'd1 + cnt_reg);
                end
            end
            default:
            begin
                gx = x0_reg;
                gy = y0_reg;
            end
        endcase
    end

    // Stage 1: clip and address; stage 2: modify with forwarding of the last write.
    always_comb
    begin
        on_screen = (9'(p1_x_reg) < 9'(COLUMNS)) && (9'(p1_y_reg) < 9'(ROWS));
        addr_w    = 32'(p1_x_reg) + 32'(COLUMNS) * 32'(p1_y_reg[7:3]);
        addr1     = addr_w[AW-1:0];

        // The byte written last cycle is not yet visible to a read issued in that cycle.
        base_byte = (wl_valid_reg && (wl_addr_reg == p2_addr_reg)) ? wl_data_reg : ram_rdata;
        bit_mask  = 8'd1 << p2_bit_reg;
        new_byte  = p2_on_reg ? (base_byte | bit_mask) : (base_byte & ~bit_mask);

        p2_valid_next = p1_valid_reg && on_screen;
        p2_addr_next  = addr1;
        p2_bit_next   = p1_y_reg[2:0];
        p2_on_next    = p1_on_reg;
        wl_valid_next = p2_valid_reg;
        wl_addr_next  = p2_addr_reg;
        wl_data_next  = new_byte;

        ram_raddr = (state_reg == ST_READ) ? idx_reg : addr1;
        ram_we    = (state_reg == ST_CLEAR) || p2_valid_reg;
        ram_waddr = (state_reg == ST_CLEAR) ? clr_reg : p2_addr_reg;
        ram_wdata = (state_reg == ST_CLEAR) ? 8'd0 : new_byte;
    end

    // Command sequencer.
    always_comb
    begin
        state_next     = state_reg;
        drain_next     = drain_reg;
        clr_cmd_next   = clr_cmd_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        op_next        = op_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        span_next      = span_reg;
        tall_next      = tall_reg;
        ink_next       = ink_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        side_next      = side_reg;
        phase_next     = phase_reg;
        res_next       = res_reg;
        p1_valid_next  = 1'b0;
        p1_x_next      = gx;
        p1_y_next      = gy;
        p1_on_next     = gon;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    op_next    = s_tuser;
                    x0_next    = s_tdata[7:0];
                    y0_next    = s_tdata[15:8];
                    span_next  = s_tdata[23:16];
                    tall_next  = s_tdata[31:24];
                    ink_next   = s_tdata[32];
                    idx_next   = in_idx_w[AW-1:0];
                    cnt_next   = 8'd0;
                    side_next  = 1'b0;
                    phase_next = 1'b0;
                    res_next   = 8'd0;
                    case (s_tuser)
                        OP_PIXEL:
                        begin
                            state_next = ST_DRAW;
                        end
                        OP_HLINE, OP_VLINE:
                        begin
                            state_next = (s_tdata[23:16] == 8'd0) ? ST_DONE : ST_DRAW;
                        end
                        OP_RECT:
                        begin
                            state_next = ((s_tdata[23:16] == 8'd0) || (s_tdata[31:24] == 8'd0))
                                       ? ST_DONE : ST_DRAW;
                        end
                        OP_CLEAR:
                        begin
                            state_next   = ST_CLEAR;
                            clr_cmd_next = 1'b1;
                            clr_next     = '0;
                        end
                        OP_READ:
                        begin
                            state_next = (in_idx_w < 32'(DEPTH)) ? ST_READ : ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DRAW:
            begin
                p1_valid_next = 1'b1;
                drain_next    = 1'b0;
                case (op_reg)
                    OP_HLINE, OP_VLINE:
                    begin
                        cnt_next = 8'(cnt_reg + 8'd1);
                        if (line_end)
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                    OP_RECT:
                    begin
                        // Steps alternate top and bottom, or left and right side; cnt advances after each pair.
                        side_next = !side_reg;
                        if (side_reg)
                        begin
                            cnt_next = 8'(cnt_reg + 8'd1);
                        end
                        if (!phase_reg && top_end)
                        begin
                            cnt_next = 8'd0;
                            if (tall_reg >= 8'd3)
                            begin
                                phase_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_DRAIN;
                            end
                        end
                        if (phase_reg && side_end)
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DRAIN;
                    end
                endcase
            end
            ST_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CLEAR:
            begin
                clr_next = AW'(clr_reg + 1'b1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next   = clr_cmd_reg ? ST_DONE : ST_IDLE;
                    clr_cmd_next = 1'b0;
                end
            end
            ST_READ:
            begin
                state_next = ST_RDWAIT;
            end
            ST_RDWAIT:
            begin
                res_next   = ram_rdata;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            drain_reg     <= 1'b0;
            clr_cmd_reg   <= 1'b0;
            clr_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            wl_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= 8'd0;
        end
        else
        begin
            state_reg     <= state_next;
            drain_reg     <= drain_next;
            clr_cmd_reg   <= clr_cmd_next;
            clr_reg       <= clr_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            wl_valid_reg  <= wl_valid_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        x0_reg      <= x0_next;
        y0_reg      <= y0_next;
        span_reg    <= span_next;
        tall_reg    <= tall_next;
        ink_reg     <= ink_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        side_reg    <= side_next;
        phase_reg   <= phase_next;
        res_reg     <= res_next;
        p1_x_reg    <= p1_x_next;
        p1_y_reg    <= p1_y_next;
        p1_on_reg   <= p1_on_next;
        p2_addr_reg <= p2_addr_next;
        p2_bit_reg  <= p2_bit_next;
        p2_on_reg   <= p2_on_next;
        wl_addr_reg <= wl_addr_next;
        wl_data_reg <= wl_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The pixel pipeline must be empty whenever a new word can be taken or a result is posted.
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!p1_valid_reg && !p2_valid_reg))
        else $error("pixel pipeline busy while accepting a command");

    a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (!p1_valid_reg && !p2_valid_reg && !ram_we))
        else $error("result posted before the last pixel was written");

    // Clearing owns the write port and writes only zeros.
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (ram_we && (ram_wdata == 8'd0) && !p2_valid_reg))
        else $error("clearing pass collides with a pixel write");

    // A write in stage 2 comes from a pixel that was in stage 1 the cycle before.
    a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
        p2_valid_reg |-> $past(p1_valid_reg))
        else $error("stage 2 write without a stage 1 pixel");

endmodule
